// ----- design/srppm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srppm_pkg
// Shared types and constants for the serial RC frame to PPM converter.
// ----------------------------------------------------------------------------
`default_nettype none

package srppm_pkg;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_COMPARE = 1'b1;

    localparam logic [7:0] SYNC_PREV    = 8'h03;
    localparam logic [7:0] SYNC_CUR     = 8'h01;
    localparam logic [4:0] COUNT_MAX    = 5'd20;
    localparam logic [4:0] COMMIT_COUNT = 5'd12;
    localparam logic [4:0] FIRST_COUNT  = 5'd2;

    localparam int PULSE_BASE_US = 884;
    localparam int DEFAULT_US    = 1500;
    localparam int FRAME_US      = 28000;

    localparam int US_W    = 12;
    localparam int TICKS_W = 16;
    localparam int VALUE_W = 10;
    localparam int CIDX_W  = 3;

    localparam int REG_FRAME_TICKS = 0;
    localparam int ADDR_W          = 3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                step;
        logic                dec_en;
        logic                commit;
        logic [CIDX_W-1:0]   dec_idx;
        logic [VALUE_W-1:0]  dec_val;
    } srppm_cmd_t;

endpackage

`default_nettype wire

// ----- design/srppm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srppm_front
// Input side: tracks serial frame position and turns beats into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module srppm_front #(
    parameter int CHANNELS = 8
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [7:0]                s_tdata,   // [7:0] rx_byte
    input  wire  [0:0]                s_tuser,   // [0] func
    input  wire                       q_full,
    output logic                      q_push,
    output srppm_pkg::srppm_cmd_t     q_cmd
);
    import srppm_pkg::*;

    logic [4:0] byte_count_reg, byte_count_next;
    logic [7:0] prev_byte_reg;
    logic [4:0] cnt_eff;
    logic [3:0] idx;
    logic       dec_hit, dec_en, commit, accept, is_byte;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_byte  = (s_tuser[0] == FUNC_BYTE);

    always_comb begin
        cnt_eff = (prev_byte_reg == SYNC_PREV && s_tdata == SYNC_CUR) ? 5'd0 : byte_count_reg;
        dec_hit = (cnt_eff >= FIRST_COUNT) && (cnt_eff <= COMMIT_COUNT) && !cnt_eff[0];
        idx     = cnt_eff[4:1] - 4'd1;
        dec_en  = dec_hit && ({1'b0, idx} < 5'(CHANNELS));
        commit  = (cnt_eff == COMMIT_COUNT);
        byte_count_next = (cnt_eff < COUNT_MAX) ? cnt_eff + 5'd1 : cnt_eff;
    end

    always_comb begin
        q_cmd.step    = !is_byte;
        q_cmd.dec_en  = is_byte && dec_en;
        q_cmd.commit  = is_byte && commit;
        q_cmd.dec_idx = idx[CIDX_W-1:0];
        q_cmd.dec_val = {prev_byte_reg[1:0], s_tdata};
        q_push = accept && (!is_byte || dec_en || commit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 5'd0;
            prev_byte_reg  <= 8'd0;
        end else if (accept && is_byte) begin
            byte_count_reg <= byte_count_next;
            prev_byte_reg  <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/srppm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srppm_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module srppm_fifo (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  srppm_pkg::srppm_cmd_t     push_cmd,
    input  wire                       pop,
    output srppm_pkg::srppm_cmd_t     pop_cmd,
    output logic                      full,
    output logic                      empty
);
    import srppm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    srppm_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/srppm_tick_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srppm_tick_div
// Division by a constant through one reciprocal multiply; the quotient is
// valid the cycle after start and is exact for every numerator below
// 2**NUM_W.
// ----------------------------------------------------------------------------
`default_nettype none

module srppm_tick_div #(
    parameter int NUM_W   = 28,
    parameter int DIVISOR = 64000
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire  [NUM_W-1:0]    numer,
    output logic                done,
    output logic [NUM_W-1:0]    quot
);
    localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
    localparam int RCP_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    logic [PROD_W-1:0] prod_reg;
    logic              done_reg;

    assign done = done_reg;
    assign quot = NUM_W'(prod_reg >> SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_W'(numer) * PROD_W'(RCP);
        end
    end

endmodule

`default_nettype wire

// ----- design/srppm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srppm_back
// Execution side: stores decoded channels, converts them to timer ticks on
// commit, and steps through the PPM slots on compare events.
// ----------------------------------------------------------------------------
`default_nettype none

module srppm_back #(
    parameter int CHANNELS       = 8,
    parameter int CLOCK_KHZ      = 16000,
    parameter int TIMER_PRESCALE = 64
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       q_empty,
    input  srppm_pkg::srppm_cmd_t     q_cmd,
    output logic                      q_pop,
    input  wire  [15:0]               frame_ticks,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [23:0]               m_tdata    // [15:0] period_ticks, [19:16] slot
);
    import srppm_pkg::*;

    localparam int IDX_W  = $clog2(CHANNELS);
    localparam int SLOT_W = $clog2(CHANNELS + 1);
    localparam int NUM_W  = $clog2(CLOCK_KHZ * (PULSE_BASE_US + 1279 + 1));
    localparam int DIV_K  = 1000 * TIMER_PRESCALE;
    localparam int DEF_RAW = CLOCK_KHZ * DEFAULT_US / 1000 / TIMER_PRESCALE;
    localparam logic [TICKS_W-1:0] DEF_TICKS =
        (DEF_RAW > 65535) ? 16'hFFFF : TICKS_W'(DEF_RAW);
    localparam logic [SLOT_W-1:0] SLOT_SYNC = SLOT_W'(CHANNELS);
    localparam logic [SLOT_W:0]   SLOT_WRAP = (SLOT_W+1)'(CHANNELS + 1);
    localparam logic [IDX_W-1:0]  LAST_CH   = IDX_W'(CHANNELS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    ch_reg, ch_next;
    logic [VALUE_W-1:0]  decoded_reg [CHANNELS];
    logic [TICKS_W-1:0]  slot_ticks_reg [CHANNELS];
    logic [SLOT_W-1:0]   cur_slot_reg;
    logic [TICKS_W-1:0]  gap_reg;
    logic [NUM_W-1:0]    numer_reg;
    logic                m_tvalid_reg;
    logic [TICKS_W-1:0]  period_reg;
    logic [3:0]          slot_out_reg;

    logic                out_free, do_step, div_start, div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [TICKS_W-1:0]  tick_sat;
    logic [VALUE_W-1:0]  cval;
    logic [US_W-1:0]     pulse_us;
    logic [SLOT_W:0]     slot_inc;
    logic [SLOT_W-1:0]   new_slot;
    logic [TICKS_W-1:0]  gap_base, gap_new, period;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty && (!q_cmd.step || out_free);
    assign do_step   = q_pop && q_cmd.step;
    assign div_start = (state_reg == ST_START);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0, slot_out_reg, period_reg};

    always_comb begin
        cval     = decoded_reg[ch_reg];
        pulse_us = US_W'(PULSE_BASE_US) + {2'b0, cval} + {4'b0, cval[VALUE_W-1:2]};
        tick_sat = (|div_quot[NUM_W-1:TICKS_W]) ? 16'hFFFF : div_quot[TICKS_W-1:0];
    end

    always_comb begin
        slot_inc = {1'b0, cur_slot_reg} + (SLOT_W+1)'(1);
        if (slot_inc >= SLOT_WRAP) begin
            new_slot = '0;
            gap_base = frame_ticks;
        end else begin
            new_slot = slot_inc[SLOT_W-1:0];
            gap_base = gap_reg;
        end
        if (new_slot < SLOT_SYNC) begin
            period  = slot_ticks_reg[new_slot[IDX_W-1:0]];
            gap_new = gap_base - period;
        end else begin
            period  = gap_base;
            gap_new = gap_base;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop && q_cmd.commit) begin
                    state_next = ST_LOAD;
                    ch_next    = '0;
                end
            end
            ST_LOAD:  state_next = ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (div_done) begin
                    if (ch_reg == LAST_CH) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD;
                        ch_next    = ch_reg + IDX_W'(1);
                    end
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            cur_slot_reg <= SLOT_W'(1);
            gap_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                decoded_reg[k]    <= '0;
                slot_ticks_reg[k] <= DEF_TICKS;
            end
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (q_pop && q_cmd.dec_en) begin
                decoded_reg[IDX_W'(q_cmd.dec_idx)] <= q_cmd.dec_val;
            end
            if (state_reg == ST_WAIT && div_done) begin
                slot_ticks_reg[ch_reg] <= tick_sat;
            end
            if (do_step) begin
                cur_slot_reg <= new_slot;
                gap_reg      <= gap_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            numer_reg <= NUM_W'(CLOCK_KHZ) * {{(NUM_W-US_W){1'b0}}, pulse_us};
        end
        if (do_step) begin
            period_reg   <= period;
            slot_out_reg <= 4'(new_slot);
        end
    end

    srppm_tick_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (DIV_K)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numer_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped during commit");

    a_commit_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.commit) |=> state_reg == ST_LOAD && ch_reg == '0)
        else $error("commit did not start conversion");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_slot_reg <= SLOT_SYNC)
        else $error("slot out of range");

    a_step_free: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |-> out_free)
        else $error("result overwritten before taken");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside conversion");

endmodule

`default_nettype wire

// ----- design/serial_rc_frame_to_ppm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rc_frame_to_ppm_core
// Serial RC receiver frames in, PPM timer periods out.
// ----------------------------------------------------------------------------
// Bytes and compare events enter on the s_ stream (tuser = func) and are
// queued as commands in a four-entry queue. A compare event is answered in
// the cycle after it leaves the queue, which it does only when the output
// register is free. The byte that completes a frame (the twelfth) starts
// the tick conversion of all channels through one shared reciprocal
// multiplier, each channel passing through a load, a start and a wait
// state. Later beats keep entering the queue meanwhile while it has room
// and run in order after it. frame_ticks sits at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rc_frame_to_ppm_core #(
    parameter int CHANNELS       = 8,
    parameter int CLOCK_KHZ      = 16000,
    parameter int TIMER_PRESCALE = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire  [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [15:0] period_ticks, [19:16] slot
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srppm_pkg::*;

    localparam int FRAME_RAW = CLOCK_KHZ * FRAME_US / 1000 / TIMER_PRESCALE;
    localparam logic [TICKS_W-1:0] FRAME_RESET =
        (FRAME_RAW > 65535) ? 16'hFFFF : TICKS_W'(FRAME_RAW);
    localparam logic [ADDR_W-1:0] ADDR_FRAME = ADDR_W'(4 * REG_FRAME_TICKS);

    logic [TICKS_W-1:0] frame_ticks_reg;
    logic               q_push, q_pop, q_full, q_empty;
    srppm_cmd_t         push_cmd, pop_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FRAME) ? {16'b0, frame_ticks_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_ticks_reg <= FRAME_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_FRAME) begin
            frame_ticks_reg <= pwdata[TICKS_W-1:0];
        end
    end

    srppm_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    srppm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    srppm_back #(
        .CHANNELS       (CHANNELS),
        .CLOCK_KHZ      (CLOCK_KHZ),
        .TIMER_PRESCALE (TIMER_PRESCALE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .frame_ticks (frame_ticks_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
